// ===== hw/rtl/json_string_unescaper_unit_defines.svh =====
// Assertion helpers for the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPER_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPER_UNIT_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked only out of reset.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int UNIT_W = 21;
    localparam int MAX_RES = 3;

    typedef enum logic [3:0] {
        PH_PLAIN   = 4'd0,
        PH_ESC     = 4'd1,
        PH_HEX1    = 4'd2,
        PH_HEX2    = 4'd3,
        PH_HEX3    = 4'd4,
        PH_HEX4    = 4'd5,
        PH_WANT_BS = 4'd6,
        PH_WANT_U  = 4'd7,
        PH_LO1     = 4'd8,
        PH_LO2     = 4'd9,
        PH_LO3     = 4'd10,
        PH_LO4     = 4'd11
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    localparam logic [UNIT_W-1:0] C_SPACE     = 21'h00020;
    localparam logic [UNIT_W-1:0] C_QUOTE     = 21'h00022;
    localparam logic [UNIT_W-1:0] C_SLASH     = 21'h0002F;
    localparam logic [UNIT_W-1:0] C_BACKSLASH = 21'h0005C;
    localparam logic [UNIT_W-1:0] C_LTR_B     = 21'h00062;
    localparam logic [UNIT_W-1:0] C_LTR_F     = 21'h00066;
    localparam logic [UNIT_W-1:0] C_LTR_N     = 21'h0006E;
    localparam logic [UNIT_W-1:0] C_LTR_R     = 21'h00072;
    localparam logic [UNIT_W-1:0] C_LTR_T     = 21'h00074;
    localparam logic [UNIT_W-1:0] C_LTR_U     = 21'h00075;
    localparam logic [UNIT_W-1:0] C_BS_CHAR   = 21'h00008;
    localparam logic [UNIT_W-1:0] C_FF_CHAR   = 21'h0000C;
    localparam logic [UNIT_W-1:0] C_LF_CHAR   = 21'h0000A;
    localparam logic [UNIT_W-1:0] C_CR_CHAR   = 21'h0000D;
    localparam logic [UNIT_W-1:0] C_TAB_CHAR  = 21'h00009;
    localparam logic [UNIT_W-1:0] C_SUPP_BASE = 21'h10000;
    localparam logic [15:0]       C_HI_MIN    = 16'hD800;
    localparam logic [15:0]       C_HI_MAX    = 16'hDBFF;
    localparam logic [15:0]       C_LO_MIN    = 16'hDC00;
    localparam logic [15:0]       C_LO_MAX    = 16'hDFFF;
    localparam logic [5:0]        C_HI_TAG    = 6'b110110;
    localparam logic [5:0]        C_LO_TAG    = 6'b110111;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] acc;
        logic [9:0]  hi;
        logic        failed;
    } t_state;

    // Results caused by one request, slot 0 first.
    typedef struct packed {
        logic [1:0]                       cnt;
        logic [MAX_RES-1:0][UNIT_W-1:0]   units;
        logic [MAX_RES-1:0][1:0]          kinds;
    } t_bundle;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [UNIT_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 21'h30 && c <= 21'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/jsu_decode.sv =====
`timescale 1ns / 1ps

module jsu_decode import jsu_pkg::*; (
    input  t_state             i_state,
    input  logic               i_narrow,
    input  logic [UNIT_W-1:0]  i_unit,
    input  logic               i_eos,
    output t_state             o_next,
    output t_bundle            o_bundle
);

    logic [4:0]  w_hex;
    logic [15:0] w_acc_new;

    assign w_hex     = hex_digit(i_unit);
    assign w_acc_new = {i_state.acc[11:0], w_hex[3:0]};

    always_comb begin
        logic        err;
        logic [1:0]  cnt;
        t_state      nx;
        t_bundle     b;
        err = 1'b0;
        cnt = 2'd0;
        nx  = i_state;
        b   = '0;

        if (i_state.failed) begin
            if (i_eos) begin
                nx = '0;
            end
        end else begin
            case (i_state.phase)
                PH_ESC: begin
                    nx.phase = PH_PLAIN;
                    case (i_unit)
                        C_QUOTE, C_BACKSLASH, C_SLASH: begin
                            b.units[cnt] = i_unit; cnt = cnt + 2'd1;
                        end
                        C_LTR_B: begin b.units[cnt] = C_BS_CHAR;  cnt = cnt + 2'd1; end
                        C_LTR_F: begin b.units[cnt] = C_FF_CHAR;  cnt = cnt + 2'd1; end
                        C_LTR_N: begin b.units[cnt] = C_LF_CHAR;  cnt = cnt + 2'd1; end
                        C_LTR_R: begin b.units[cnt] = C_CR_CHAR;  cnt = cnt + 2'd1; end
                        C_LTR_T: begin b.units[cnt] = C_TAB_CHAR; cnt = cnt + 2'd1; end
                        C_LTR_U: begin
                            nx.phase = PH_HEX1;
                            nx.acc   = 16'd0;
                        end
                        default: err = 1'b1;
                    endcase
                end
                PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
                    if (!w_hex[4]) begin
                        err = 1'b1;
                    end else begin
                        nx.acc = w_acc_new;
                        if (i_state.phase == PH_HEX4) begin
                            if (w_acc_new >= C_HI_MIN && w_acc_new <= C_HI_MAX) begin
                                nx.hi    = w_acc_new[9:0];
                                nx.phase = PH_WANT_BS;
                            end else if (w_acc_new >= C_LO_MIN && w_acc_new <= C_LO_MAX) begin
                                err = 1'b1;
                            end else begin
                                b.units[cnt] = {5'd0, w_acc_new};
                                cnt = cnt + 2'd1;
                                nx.phase = PH_PLAIN;
                            end
                        end else begin
                            nx.phase = t_phase'(i_state.phase + 4'd1);
                        end
                    end
                end
                PH_WANT_BS: begin
                    if (i_unit == C_BACKSLASH) nx.phase = PH_WANT_U;
                    else err = 1'b1;
                end
                PH_WANT_U: begin
                    if (i_unit == C_LTR_U) begin
                        nx.phase = PH_LO1;
                        nx.acc   = 16'd0;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_LO1, PH_LO2, PH_LO3, PH_LO4: begin
                    if (!w_hex[4]) begin
                        err = 1'b1;
                    end else begin
                        nx.acc = w_acc_new;
                        if (i_state.phase == PH_LO4) begin
                            if (w_acc_new < C_LO_MIN || w_acc_new > C_LO_MAX) begin
                                err = 1'b1;
                            end else begin
                                if (i_narrow) begin
                                    b.units[cnt] = {5'd0, C_HI_TAG, i_state.hi};
                                    cnt = cnt + 2'd1;
                                    b.units[cnt] = {5'd0, C_LO_TAG, w_acc_new[9:0]};
                                    cnt = cnt + 2'd1;
                                end else begin
                                    b.units[cnt] = C_SUPP_BASE
                                        + {1'b0, i_state.hi, w_acc_new[9:0]};
                                    cnt = cnt + 2'd1;
                                end
                                nx.phase = PH_PLAIN;
                            end
                        end else begin
                            nx.phase = t_phase'(i_state.phase + 4'd1);
                        end
                    end
                end
                default: begin
                    // plain text; unused codes land here too
                    nx.phase = PH_PLAIN;
                    if (i_unit < C_SPACE) begin
                        err = 1'b1;
                    end else if (i_unit == C_BACKSLASH) begin
                        nx.phase = PH_ESC;
                    end else begin
                        b.units[cnt] = i_unit;
                        cnt = cnt + 2'd1;
                    end
                end
            endcase

            // string cut off inside an escape
            if (!err && i_eos && nx.phase != PH_PLAIN) err = 1'b1;

            if (err) begin
                b.units[cnt] = '0;
                b.kinds[cnt] = KIND_ERR;
                cnt = cnt + 2'd1;
                if (i_eos) nx = '0;
                else nx.failed = 1'b1;
            end else if (i_eos) begin
                b.units[cnt] = '0;
                b.kinds[cnt] = KIND_OK;
                cnt = cnt + 2'd1;
                nx = '0;
            end
        end

        b.cnt    = cnt;
        o_next   = nx;
        o_bundle = b;
    end

endmodule

// ===== hw/rtl/jsu_out_buf.sv =====
`timescale 1ns / 1ps

module jsu_out_buf import jsu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_bundle            i_bundle,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [UNIT_W-1:0]  o_unit,
    output logic [1:0]         o_kind,
    output logic               o_last
);

    logic    r_valid;
    logic    n_valid;
    logic [1:0] r_sel;
    logic [1:0] n_sel;
    t_bundle r_bundle;
    logic    w_fire;

    assign o_valid    = r_valid;
    assign o_unit     = r_bundle.units[r_sel];
    assign o_kind     = r_bundle.kinds[r_sel];
    assign o_last     = (r_sel == r_bundle.cnt - 2'd1);
    assign w_fire     = r_valid && i_ready;
    assign o_can_load = !r_valid || (w_fire && o_last);

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        if (i_load) begin
            n_valid = 1'b1;
            n_sel   = 2'd0;
        end else if (w_fire && o_last) begin
            n_valid = 1'b0;
            n_sel   = 2'd0;
        end else if (w_fire) begin
            n_sel = r_sel + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_bundle <= i_bundle;
    end

endmodule

// ===== hw/rtl/json_string_unescaper_unit.sv =====
`timescale 1ns / 1ps
//  Channel   Direction  Handshake          Payload
//  input     in         i_valid/o_ready    i_code_unit, i_end_of_string
//  result    out        o_valid/i_ready    o_out_unit, o_out_kind, o_run_last
//  config    in         i_cfg_we           i_cfg_wdata (narrow_units)
//
//  One request per cycle while i_ready is high and each request yields at most
//  one result; one with several results (up to 3) holds the single result port
//  until all are sent. Requests pass the input register, then the result buffer.
//  Reset is synchronous, active low; it clears the decode state and narrow mode.
//  A stalled result port backs up into the input register, then o_ready drops.

module json_string_unescaper_unit import jsu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [UNIT_W-1:0]  i_code_unit,
    input  logic               i_end_of_string,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [UNIT_W-1:0]  o_out_unit,
    output logic [1:0]         o_out_kind,
    output logic               o_run_last,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

`include "json_string_unescaper_unit_defines.svh"

    // input register
    logic              r_in_valid;
    logic [UNIT_W-1:0] r_in_unit;
    logic              r_in_eos;

    // per-string decode state and mode register
    t_state            r_state;
    logic              r_narrow;

    t_state            w_next;
    t_bundle           w_bundle;
    logic              w_can_load;
    logic              w_advance;
    logic              w_load;

    // A request with no results (inside a failed string, or a partial escape)
    // retires without needing the result buffer.
    assign w_advance = r_in_valid && ((w_bundle.cnt == 2'd0) || w_can_load);
    assign w_load    = w_advance && (w_bundle.cnt != 2'd0);
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_unit <= i_code_unit;
            r_in_eos  <= i_end_of_string;
        end
    end

    // state moves only when the request in the input register retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow <= 1'b0;
        end else if (i_cfg_we) begin
            r_narrow <= i_cfg_wdata;
        end
    end

    jsu_decode u_decode (
        .i_state  (r_state),
        .i_narrow (r_narrow),
        .i_unit   (r_in_unit),
        .i_eos    (r_in_eos),
        .o_next   (w_next),
        .o_bundle (w_bundle)
    );

    // result buffer: holds one request's results, sends one per cycle while i_ready is high
    jsu_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_bundle   (w_bundle),
        .o_can_load (w_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_unit     (o_out_unit),
        .o_kind     (o_out_kind),
        .o_last     (o_run_last)
    );

    // status results always close the request's results
    `JSU_ASSERT_NOW(a_status_is_last, i_clk, i_rst_n, o_valid && (o_out_kind != KIND_CHAR), o_run_last)
    // a failed string stays silent
    `JSU_ASSERT_NOW(a_failed_silent, i_clk, i_rst_n, r_in_valid && r_state.failed, w_bundle.cnt == 2'd0)
    // every string end returns to a clean state
    `JSU_ASSERT_NEXT(a_eos_clears, i_clk, i_rst_n, w_advance && r_in_eos, (r_state.phase == PH_PLAIN) && !r_state.failed)

endmodule
